// ===== hdl/spp_pkg.sv =====
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package spp_pkg;

   localparam int SLOTS  = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic OP_ADMIT = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [1:0] KIND_DONE = 2'd0;
   localparam logic [1:0] KIND_FULL = 2'd1;
   localparam logic [1:0] KIND_ZERO = 2'd2;

   typedef struct packed {
      logic        op;
      logic [7:0]  task_id;
      logic [7:0]  task_priority;
      logic [15:0] burst_len;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  done_id;
      logic [31:0] done_at;
      logic [31:0] turnaround;
      logic [31:0] waiting_time;
   } rsp_type;

   // One row of the slot table
   typedef struct packed {
      logic [7:0]  task_id;
      logic [7:0]  priority_num;
      logic [31:0] arrival;
      logic [15:0] remaining;
      logic [15:0] burst;
   } slot_type;

   // Ordering key used by the selection comparator
   typedef struct packed {
      logic [7:0]  priority_num;
      logic [31:0] arrival;
   } key_type;

endpackage

`default_nettype wire

// ===== hdl/spp_slot_ram.sv =====
// Slot table storage: one write port and one registered read port.
// Depends on spp_pkg for the row type and table depth.
`default_nettype none

module spp_slot_ram (
   input  wire                   clock,
   input  wire                   wr_en,
   input  wire [spp_pkg::SLOT_W-1:0] wr_addr,
   input  wire spp_pkg::slot_type wr_data,
   input  wire [spp_pkg::SLOT_W-1:0] rd_addr,
   output spp_pkg::slot_type     rd_data
);
   import spp_pkg::*;

   slot_type mem [SLOTS];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/spp_cmp.sv =====
// Selection comparator shared by every step of the slot scan.
// Depends on spp_pkg for the key type.
`default_nettype none

module spp_cmp (
   input  wire spp_pkg::key_type cand_key,
   input  wire spp_pkg::key_type best_key,
   input  wire              best_found,
   output logic             take
);
   import spp_pkg::*;

   // Strict compares keep the earlier (lower) slot on a full tie
   always_comb begin
      take = !best_found
          || (cand_key.priority_num < best_key.priority_num)
          || ((cand_key.priority_num == best_key.priority_num)
              && (cand_key.arrival < best_key.arrival));
   end

endmodule

`default_nettype wire

// ===== hdl/preemptive_priority_scheduler.sv =====
// Top level of the preemptive priority scheduler: sequencer, valid bits and time.
// Depends on spp_pkg, spp_slot_ram and spp_cmp.
`default_nettype none

// Each beat taken on start/busy walks the whole slot table through one read
// port of the slot RAM and one comparator, one slot per cycle: an admit or an
// idle or unfinished tick keeps busy high through the scan, a last-compare step
// and an apply step, and a tick that finishes a task also passes through an
// emit step to form its waiting time. A result appears on rsp_data with
// rsp_valid high for exactly one cycle and is not held; the receiver cannot
// stall it. Successful admits and ticks that do not finish a task give no result.

module preemptive_priority_scheduler (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  wire spp_pkg::req_type req_data,
   output logic             rsp_valid,
   output spp_pkg::rsp_type rsp_data
);
   import spp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_APPLY,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic              best_found_ff, best_found_in;
   logic [SLOT_W-1:0] best_idx_ff, best_idx_in;
   slot_type          best_ff, best_in;
   logic              free_found_ff, free_found_in;
   logic [SLOT_W-1:0] free_idx_ff, free_idx_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [31:0]       now_ff, now_in;
   logic [31:0]       tat_ff, tat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   slot_type          wr_data;
   slot_type          rd_data;
   key_type           cand_key;
   key_type           best_key;
   logic              take;
   logic [15:0]       rem_next;

   spp_slot_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign cand_key = {rd_data.priority_num, rd_data.arrival};
   assign best_key = {best_ff.priority_num, best_ff.arrival};

   spp_cmp u_cmp (
      .cand_key   (cand_key),
      .best_key   (best_key),
      .best_found (best_found_ff),
      .take       (take)
   );

   assign rem_next = best_ff.remaining - 16'd1;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      now_in        = now_ff;
      tat_in        = tat_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = free_idx_ff;
      wr_data.task_id      = req_ff.task_id;
      wr_data.priority_num = req_ff.task_priority;
      wr_data.arrival      = now_ff;
      wr_data.remaining    = req_ff.burst_len;
      wr_data.burst        = req_ff.burst_len;

      // Compare stage: RAM data for cmp_idx arrives in the cycle after its read
      if (cmp_vld_ff && (req_ff.op == OP_TICK) && valid_ff[cmp_idx_ff] && take) begin
         best_found_in = 1'b1;
         best_idx_in   = cmp_idx_ff;
         best_in       = rd_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in        = req_data;
               idx_in        = '0;
               best_found_in = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            cmp_idx_in = idx_ff;
            if (!valid_ff[idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            if (idx_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = ST_LAST;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_LAST: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
            if (req_ff.op == OP_ADMIT) begin
               rsp_in.done_id      = req_ff.task_id;
               rsp_in.done_at      = '0;
               rsp_in.turnaround   = '0;
               rsp_in.waiting_time = '0;
               if (req_ff.burst_len == 16'd0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.kind  = KIND_ZERO;
               end else if (!free_found_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.kind  = KIND_FULL;
               end else begin
                  wr_en                 = 1'b1;
                  valid_in[free_idx_ff] = 1'b1;
               end
            end else begin
               now_in = now_ff + 32'd1;
               if (best_found_ff) begin
                  wr_en     = 1'b1;
                  wr_addr   = best_idx_ff;
                  wr_data   = best_ff;
                  wr_data.remaining = rem_next;
                  if (rem_next == 16'd0) begin
                     valid_in[best_idx_ff] = 1'b0;
                     tat_in   = now_ff + 32'd1 - best_ff.arrival;
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.kind         = KIND_DONE;
            rsp_in.done_id      = best_ff.task_id;
            rsp_in.done_at      = now_ff;
            rsp_in.turnaround   = tat_ff;
            rsp_in.waiting_time = tat_ff - {16'd0, best_ff.burst};
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         valid_ff     <= valid_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      tat_ff        <= tat_in;
      rsp_ff        <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the preemptive priority scheduler.
// Depends on spp_pkg and preemptive_priority_scheduler; compares each result
// with a cycle-free scheduling model that is kept inside this file.
`timescale 1ns / 1ps

module tb;
   import spp_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   preemptive_priority_scheduler u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Scheduling model state
   logic        slot_busy [SLOTS];
   slot_type    slot_row  [SLOTS];
   logic [31:0] sched_time;

   req_type cmd_q[$];
   rsp_type outcome_q[$];
   int      failures = 0;

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         slot_busy[s] = 1'b0;
         slot_row[s]  = '0;
      end
      sched_time = '0;
   end

   // Apply one accepted beat to the model; return 1 when it yields a result.
   function automatic bit schedule_beat(input req_type cmd, output rsp_type outcome);
      int          free_idx;
      int          pick;
      logic [31:0] tat;
      outcome = '0;
      if (cmd.op == OP_ADMIT) begin
         outcome.done_id = cmd.task_id;
         if (cmd.burst_len == 16'd0) begin
            outcome.kind = KIND_ZERO;
            return 1'b1;
         end
         free_idx = -1;
         for (int s = 0; s < SLOTS; s++)
            if (!slot_busy[s] && free_idx < 0)
               free_idx = s;
         if (free_idx < 0) begin
            outcome.kind = KIND_FULL;
            return 1'b1;
         end
         slot_busy[free_idx]             = 1'b1;
         slot_row[free_idx].task_id      = cmd.task_id;
         slot_row[free_idx].priority_num = cmd.task_priority;
         slot_row[free_idx].arrival      = sched_time;
         slot_row[free_idx].remaining    = cmd.burst_len;
         slot_row[free_idx].burst        = cmd.burst_len;
         return 1'b0;
      end
      // Strict less-than keeps the lowest slot on a full tie
      pick = -1;
      for (int s = 0; s < SLOTS; s++)
         if (slot_busy[s] && (pick < 0 ||
             slot_row[s].priority_num < slot_row[pick].priority_num ||
             (slot_row[s].priority_num == slot_row[pick].priority_num &&
              slot_row[s].arrival < slot_row[pick].arrival)))
            pick = s;
      sched_time = sched_time + 32'd1;
      if (pick < 0)
         return 1'b0;
      slot_row[pick].remaining = slot_row[pick].remaining - 16'd1;
      if (slot_row[pick].remaining != 16'd0)
         return 1'b0;
      tat                  = sched_time - slot_row[pick].arrival;
      slot_busy[pick]      = 1'b0;
      outcome.kind         = KIND_DONE;
      outcome.done_id      = slot_row[pick].task_id;
      outcome.done_at      = sched_time;
      outcome.turnaround   = tat;
      outcome.waiting_time = tat - {16'd0, slot_row[pick].burst};
      return 1'b1;
   endfunction

   function automatic void push_admit(input logic [7:0] id, input logic [7:0] pri,
                                      input logic [15:0] burst);
      req_type cmd;
      cmd.op            = OP_ADMIT;
      cmd.task_id       = id;
      cmd.task_priority = pri;
      cmd.burst_len     = burst;
      cmd_q = {cmd_q, cmd};
   endfunction

   function automatic void push_tick();
      req_type cmd;
      // Fill the ignored fields with noise
      cmd.op            = OP_TICK;
      cmd.task_id       = 8'($urandom);
      cmd.task_priority = 8'($urandom);
      cmd.burst_len     = 16'($urandom);
      cmd_q = {cmd_q, cmd};
   endfunction

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
         failures++;
      end
   endtask

   // Driver: hold start until the beat is taken, then wait out a drawn gap
   int gap_left   = 0;
   bit count_all  = 1'b1;
   int calm_left  = 0;

   always @(posedge clock) begin : drive
      rsp_type next_outcome;
      if (!reset) begin
         if (start && !busy) begin
            if (schedule_beat(req_data, next_outcome))
               outcome_q = {outcome_q, next_outcome};
            void'(cmd_q.pop_front());
            if (calm_left > 0) begin
               calm_left--;
               gap_left = 0;
            end else begin
               gap_left  = $urandom_range(0, 14);
               count_all = $urandom_range(0, 1);
               if ($urandom_range(0, 59) == 0)
                  calm_left = $urandom_range(10, 40);
            end
         end
         if (start && busy) begin
            // hold the current beat
         end else if (gap_left > 0) begin
            if (count_all || !busy)
               gap_left--;
            start <= 1'b0;
         end else if (cmd_q.size() != 0) begin
            start    <= 1'b1;
            req_data <= cmd_q[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe must match the oldest prediction
   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (outcome_q.size() == 0) begin
            $display("%0t ns: result with none expected, expected nothing, got %h",
                     $time, rsp_data);
            failures++;
         end else begin
            want = outcome_q.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_data.kind));
            check_field("done_id", 32'(want.done_id), 32'(rsp_data.done_id));
            check_field("done_at", want.done_at, rsp_data.done_at);
            check_field("turnaround", want.turnaround, rsp_data.turnaround);
            check_field("waiting_time", want.waiting_time, rsp_data.waiting_time);
         end
      end
   end

   initial begin : stimulus
      int          phase;
      int          span;
      int          admit_pct;
      int          roll;
      logic [7:0]  id;
      logic [7:0]  pri;
      logic [15:0] burst;
      int          n;

      // Directed: idle tick, extreme fields, same-stamp ties, full table
      push_tick();
      push_admit(8'h00, 8'hFF, 16'hFFFF);
      push_admit(8'hFF, 8'h00, 16'h0000);
      for (int i = 1; i < SLOTS; i++)
         push_admit(8'(i), 8'(i % 3), 16'(1 + i % 2));
      push_admit(8'hAA, 8'h00, 16'd5);
      push_admit(8'h55, 8'h00, 16'h0000);
      repeat (4) push_tick();

      // Random phases: fill the table, drain it, or mix
      n = 0;
      while (n < 1650) begin
         phase     = $urandom_range(0, 2);
         span      = $urandom_range(20, 60);
         admit_pct = (phase == 0) ? 65 : (phase == 1) ? 15 : 35;
         for (int k = 0; k < span && n < 1650; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < admit_pct) begin
               id  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3))
                                                 : 8'($urandom);
               pri = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                 : 8'($urandom_range(0, 3));
               roll = $urandom_range(0, 99);
               if (roll < 5)
                  burst = 16'd0;
               else if (roll < 8)
                  burst = 16'($urandom_range(9, 40));
               else
                  burst = 16'($urandom_range(1, 8));
               push_admit(id, pri, burst);
            end else begin
               push_tick();
            end
            n++;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (cmd_q.size() != 0 || start || outcome_q.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/spp_pkg.sv
hdl/spp_slot_ram.sv
hdl/spp_cmp.sv
hdl/preemptive_priority_scheduler.sv
verif/tb.sv
